@@ design/ps2m_pkg.sv @@
// ----------------------------------------------------------------------------
// ps2m_pkg
// shared constants for the ps/2 mouse start-up sequencer and packet decoder
// ----------------------------------------------------------------------------
package ps2m_pkg;

    // received byte and result payload widths
    localparam int RxW   = 8;
    localparam int OutDw = 40;

    // bytes seen from the mouse
    localparam logic [7:0] RX_ACK       = 8'hFA;
    localparam logic [7:0] RX_BAT_PASS  = 8'hAA;
    localparam logic [7:0] ID_STANDARD  = 8'h00;
    localparam logic [7:0] ID_WHEEL     = 8'h03;
    localparam logic [7:0] HDR_MASK     = 8'hC8;
    localparam logic [7:0] HDR_MATCH    = 8'h08;

    // bytes sent to the mouse
    localparam logic [7:0] CMD_SET_RATE = 8'hF3;
    localparam logic [7:0] CMD_GET_ID   = 8'hF2;
    localparam logic [7:0] CMD_ENABLE   = 8'hF4;
    localparam logic [7:0] CMD_RESET    = 8'hFF;
    localparam logic [7:0] RATE_200     = 8'd200;
    localparam logic [7:0] RATE_100     = 8'd100;
    localparam logic [7:0] RATE_80      = 8'd80;

    // result kinds carried on tuser
    localparam logic KIND_CMD    = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    // result tdata layout
    localparam int CMD_LSB    = 0;
    localparam int STATUS_LSB = 8;
    localparam int X_LSB      = 16;
    localparam int Y_LSB      = 25;
    localparam int WHEEL_LSB  = 35;
    localparam int HASW_BIT   = 39;

    // sequencer phase codes
    localparam logic [4:0] PH_WAIT_ACK  = 5'd0;
    localparam logic [4:0] PH_WAIT_BAT  = 5'd1;
    localparam logic [4:0] PH_KNOCK0    = 5'd2;
    localparam logic [4:0] PH_KNOCK1    = 5'd3;
    localparam logic [4:0] PH_KNOCK2    = 5'd4;
    localparam logic [4:0] PH_KNOCK3    = 5'd5;
    localparam logic [4:0] PH_KNOCK4    = 5'd6;
    localparam logic [4:0] PH_KNOCK5    = 5'd7;
    localparam logic [4:0] PH_WAIT_ID   = 5'd8;
    localparam logic [4:0] PH_STD_ACK   = 5'd10;
    localparam logic [4:0] PH_STD_HDR   = 5'd11;
    localparam logic [4:0] PH_STD_X     = 5'd12;
    localparam logic [4:0] PH_STD_Y     = 5'd13;
    localparam logic [4:0] PH_WHL_ACK   = 5'd20;
    localparam logic [4:0] PH_WHL_HDR   = 5'd21;
    localparam logic [4:0] PH_WHL_X     = 5'd22;
    localparam logic [4:0] PH_WHL_Y     = 5'd23;
    localparam logic [4:0] PH_WHL_Z     = 5'd24;

endpackage

@@ design/ps2_mouse_init_and_packet_decoder.sv @@
// ----------------------------------------------------------------------------
// ps2_mouse_init_and_packet_decoder
// host-side ps/2 mouse start-up sequencer and movement packet decoder
// ----------------------------------------------------------------------------
// usage
//   s_axis: one byte received from the mouse per transaction (s_tdata)
//   m_axis: one result per transaction; m_tuser gives the kind
//     kind 0: command byte to transmit to the mouse (rest of tdata is zero)
//     kind 1: movement report (status, x, negated y, wheel, wheel flag)
//   start-up: wait for ack then self-test pass, send the 200/100/80 sample
//   rate knock, ask for the id; id 0 gives 3-byte packets, id 3 gives 4-byte
//   packets with wheel, anything else sends reset again
//   not every byte produces a result: acks, sync bytes and packet body bytes
//   are absorbed silently
// timing
//   one byte per cycle sustained while m_tready stays high; a result is
//   registered onto m_axis through the input register, then the result register
//   the decode of one byte is a single pass of logic between those registers
// reset / stall
//   aresetn low returns to waiting for the reset acknowledge, mouse type back
//   to three-button, both stages emptied
//   while m_tready is low a held result stays put; the input register still
//   takes one byte, then s_tready drops until the result is taken
// ----------------------------------------------------------------------------
module ps2_mouse_init_and_packet_decoder (
    input  logic                         aclk,
    input  logic                         aresetn,
    // slave side: received bytes
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [ps2m_pkg::RxW-1:0]     s_tdata,   // [7:0] rx_byte
    // master side: commands and reports
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [ps2m_pkg::OutDw-1:0]   m_tdata,   // [7:0] command_byte,
                                                    // [15:8] status_byte,
                                                    // [24:16] move_x,
                                                    // [34:25] move_y,
                                                    // [38:35] wheel,
                                                    // [39] has_wheel
    output logic                         m_tuser    // [0] result_kind
);
    import ps2m_pkg::*;

    // input register
    logic             in_valid_reg, in_valid_next;
    logic [RxW-1:0]   in_byte_reg;

    // decoder state
    logic [4:0]       phase_reg, phase_next;
    logic             wheel_type_reg, wheel_type_next;
    logic [7:0]       hdr_reg, x_reg, y_reg;    // packet bytes, no reset needed
    logic             hdr_we, x_we, y_we;

    // result register
    logic             out_valid_reg, out_valid_next;
    logic [OutDw-1:0] out_data_reg;
    logic             out_kind_reg;

    // decoded result of the byte in the input register
    logic             res_valid;
    logic             res_kind;
    logic [OutDw-1:0] res_data;

    logic             out_free;   // result register can take a new result
    logic             advance;    // input register byte is decoded this cycle
    logic             is_ack;
    logic             is_hdr;

    // report fields
    logic [7:0]       rep_y_byte;
    logic [3:0]       rep_wheel;
    logic             rep_has_wheel;
    logic [8:0]       rep_x;
    logic [9:0]       rep_y;

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    assign is_ack = (in_byte_reg == RX_ACK);
    assign is_hdr = ((in_byte_reg & HDR_MASK) == HDR_MATCH);

    // x sign from header bit 4, y sign from header bit 5, y negated for screen
    assign rep_x = {hdr_reg[4], x_reg};
    assign rep_y = 10'd0 - {{2{hdr_reg[5]}}, rep_y_byte};

    // phase sequencer and result select
    always_comb begin
        phase_next      = phase_reg;
        wheel_type_next = wheel_type_reg;
        hdr_we          = 1'b0;
        x_we            = 1'b0;
        y_we            = 1'b0;
        res_valid       = 1'b0;
        res_kind        = KIND_CMD;
        res_data        = '0;
        rep_y_byte      = y_reg;
        rep_wheel       = 4'd0;
        rep_has_wheel   = 1'b0;

        unique case (phase_reg)
            PH_WAIT_ACK: begin
                if (is_ack) phase_next = PH_WAIT_BAT;
            end
            PH_WAIT_BAT: begin
                if (in_byte_reg == RX_BAT_PASS) begin
                    phase_next = PH_KNOCK0;
                    res_valid  = 1'b1;
                    res_data[CMD_LSB +: 8] = CMD_SET_RATE;
                end
            end
            PH_KNOCK0: begin
                if (is_ack) begin
                    phase_next = PH_KNOCK1;
                    res_valid  = 1'b1;
                    res_data[CMD_LSB +: 8] = RATE_200;
                end
            end
            PH_KNOCK1: begin
                if (is_ack) begin
                    phase_next = PH_KNOCK2;
                    res_valid  = 1'b1;
                    res_data[CMD_LSB +: 8] = CMD_SET_RATE;
                end
            end
            PH_KNOCK2: begin
                if (is_ack) begin
                    phase_next = PH_KNOCK3;
                    res_valid  = 1'b1;
                    res_data[CMD_LSB +: 8] = RATE_100;
                end
            end
            PH_KNOCK3: begin
                if (is_ack) begin
                    phase_next = PH_KNOCK4;
                    res_valid  = 1'b1;
                    res_data[CMD_LSB +: 8] = CMD_SET_RATE;
                end
            end
            PH_KNOCK4: begin
                if (is_ack) begin
                    phase_next = PH_KNOCK5;
                    res_valid  = 1'b1;
                    res_data[CMD_LSB +: 8] = RATE_80;
                end
            end
            PH_KNOCK5: begin
                if (is_ack) begin
                    phase_next = PH_WAIT_ID;
                    res_valid  = 1'b1;
                    res_data[CMD_LSB +: 8] = CMD_GET_ID;
                end
            end
            PH_WAIT_ID: begin
                // a late ack is skipped; unknown ids restart with reset
                if (!is_ack) begin
                    res_valid = 1'b1;
                    if (in_byte_reg == ID_STANDARD) begin
                        wheel_type_next = 1'b0;
                        phase_next      = PH_STD_ACK;
                        res_data[CMD_LSB +: 8] = CMD_ENABLE;
                    end else if (in_byte_reg == ID_WHEEL) begin
                        wheel_type_next = 1'b1;
                        phase_next      = PH_WHL_ACK;
                        res_data[CMD_LSB +: 8] = CMD_ENABLE;
                    end else begin
                        phase_next = PH_WAIT_ACK;
                        res_data[CMD_LSB +: 8] = CMD_RESET;
                    end
                end
            end
            PH_STD_ACK: begin
                if (is_ack) phase_next = PH_STD_HDR;
            end
            PH_STD_HDR: begin
                if (is_hdr) begin
                    hdr_we     = 1'b1;
                    phase_next = PH_STD_X;
                end
            end
            PH_STD_X: begin
                x_we       = 1'b1;
                phase_next = PH_STD_Y;
            end
            PH_STD_Y: begin
                // y byte goes straight into the report
                y_we       = 1'b1;
                phase_next = PH_STD_HDR;
                rep_y_byte = in_byte_reg;
                res_valid  = 1'b1;
                res_kind   = KIND_REPORT;
            end
            PH_WHL_ACK: begin
                if (is_ack) phase_next = PH_WHL_HDR;
            end
            PH_WHL_HDR: begin
                if (is_hdr) begin
                    hdr_we     = 1'b1;
                    phase_next = PH_WHL_X;
                end
            end
            PH_WHL_X: begin
                x_we       = 1'b1;
                phase_next = PH_WHL_Y;
            end
            PH_WHL_Y: begin
                y_we       = 1'b1;
                phase_next = PH_WHL_Z;
            end
            PH_WHL_Z: begin
                phase_next    = PH_WHL_HDR;
                rep_wheel     = in_byte_reg[3:0];
                rep_has_wheel = 1'b1;
                res_valid     = 1'b1;
                res_kind      = KIND_REPORT;
            end
            default: begin
                // unused phase codes hold
            end
        endcase

        if (res_kind == KIND_REPORT) begin
            res_data[STATUS_LSB +: 8] = hdr_reg;
            res_data[X_LSB +: 9]      = rep_x;
            res_data[Y_LSB +: 10]     = rep_y;
            res_data[WHEEL_LSB +: 4]  = rep_wheel;
            res_data[HASW_BIT]        = rep_has_wheel;
        end
    end

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = res_valid;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            phase_reg      <= PH_WAIT_ACK;
            wheel_type_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance) begin
                phase_reg      <= phase_next;
                wheel_type_reg <= wheel_type_next;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) in_byte_reg <= s_tdata;
        if (advance && hdr_we)    hdr_reg     <= in_byte_reg;
        if (advance && x_we)      x_reg       <= in_byte_reg;
        if (advance && y_we)      y_reg       <= in_byte_reg;
        if (advance && res_valid) begin
            out_data_reg <= res_data;
            out_kind_reg <= res_kind;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_kind_reg;

endmodule

@@ design/ps2m_checker.sv @@
// ----------------------------------------------------------------------------
// ps2m_checker
// port-level checks for the ps/2 mouse decoder, bound to the top level
// ----------------------------------------------------------------------------
module ps2m_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [ps2m_pkg::OutDw-1:0]   m_tdata,
    input logic                         m_tuser
);
    import ps2m_pkg::*;

    // nothing valid straight after reset
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // a stalled result holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // command results carry nothing but the command byte
    a_cmd_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == KIND_CMD) |-> m_tdata[OutDw-1:STATUS_LSB] == '0)
        else $error("command result has report bits set");

    // x sign follows header bit 4, wheel zero without a wheel mouse
    a_report_x: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == KIND_REPORT) |->
            m_tdata[X_LSB+8] == m_tdata[STATUS_LSB+4] &&
            (m_tdata[HASW_BIT] || m_tdata[WHEEL_LSB +: 4] == 4'd0) &&
            m_tdata[CMD_LSB +: 8] == 8'd0)
        else $error("report x sign or wheel field wrong");

    // y is negated: positive header sign gives zero or a negative move
    a_report_y: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == KIND_REPORT) && !m_tdata[STATUS_LSB+5] |->
            m_tdata[Y_LSB+9] || m_tdata[Y_LSB +: 10] == 10'd0)
        else $error("report y not negated");

endmodule

bind ps2_mouse_init_and_packet_decoder ps2m_checker u_ps2m_checker (.*);

@@ sim/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the ps/2 mouse start-up sequencer and packet decoder
// ----------------------------------------------------------------------------
// received bytes are queued up front and driven one transaction at a time;
// a behavioural model of the host sequencer is advanced on every accepted
// byte and leaves the command or movement report it expects; the monitor
// compares each result field by field against the oldest expectation
// ----------------------------------------------------------------------------
module testbench;
    import ps2m_pkg::*;

    localparam int StimBytes  = 1750;
    localparam int CycleLimit = 100000;
    localparam int PaceSpan   = 150;   // accepted bytes per idling phase
    localparam int HoldStart  = 600;
    localparam int HoldCycles = 400;
    localparam int TailCycles = 10;

    typedef enum int {PACE_FREE, PACE_SENDER, PACE_RECEIVER, PACE_BOTH} pace_t;

    // one result as the block reports it
    typedef struct packed {
        logic       kind;
        logic [7:0] cmd;
        logic [7:0] status;
        logic [8:0] dx;
        logic [9:0] dy;
        logic [3:0] wheel;
        logic       wflag;
    } mouse_result_t;

    logic               aclk     = 1'b0;
    logic               aresetn  = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [RxW-1:0]     s_tdata  = '0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [OutDw-1:0]   m_tdata;
    logic               m_tuser;

    logic [7:0]    rx_backlog[$];       // bytes still to be offered
    mouse_result_t awaited_results[$];  // results the model has predicted
    int            bytes_accepted = 0;
    int            error_count    = 0;
    int            cycle_count    = 0;
    int            hold_left      = 0;
    logic          hold_done      = 1'b0;

    // model state of the host sequencer
    logic [4:0] host_phase = PH_WAIT_ACK;
    logic       wheel_mode = 1'b0;
    logic [7:0] pkt_hdr    = '0;
    logic [7:0] pkt_x      = '0;
    logic [7:0] pkt_y      = '0;

    ps2_mouse_init_and_packet_decoder u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),    // [7:0] rx_byte
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),    // [7:0] command, [15:8] status, [24:16] x,
                                // [34:25] y, [38:35] wheel, [39] has_wheel
        .m_tuser  (m_tuser)     // [0] result kind
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // host sequencer model
    // ------------------------------------------------------------------------
    function automatic void note_command(input logic [7:0] cmd);
        mouse_result_t r;
        r = '0;
        r.kind = KIND_CMD;
        r.cmd  = cmd;
        awaited_results.push_back(r);
    endfunction

    function automatic void note_report(input logic [3:0] whl, input logic wflag);
        mouse_result_t r;
        logic [9:0]    y_ext;
        r        = '0;
        r.kind   = KIND_REPORT;
        r.status = pkt_hdr;
        // sign bits of x and y live in the header
        r.dx     = {pkt_hdr[4], pkt_x};
        y_ext    = {{2{pkt_hdr[5]}}, pkt_y};
        // y is flipped to screen direction
        r.dy     = 10'd0 - y_ext;
        r.wheel  = whl;
        r.wflag  = wflag;
        awaited_results.push_back(r);
    endfunction

    function automatic void decode_mouse_byte(input logic [7:0] rx);
        case (host_phase)
            PH_WAIT_ACK: begin
                if (rx == RX_ACK) host_phase = PH_WAIT_BAT;
            end
            PH_WAIT_BAT: begin
                if (rx == RX_BAT_PASS) begin
                    host_phase = PH_KNOCK0;
                    note_command(CMD_SET_RATE);
                end
            end
            // knock sequence: each sent byte waits for its acknowledge
            PH_KNOCK0: begin
                if (rx == RX_ACK) begin
                    host_phase = PH_KNOCK1;
                    note_command(RATE_200);
                end
            end
            PH_KNOCK1: begin
                if (rx == RX_ACK) begin
                    host_phase = PH_KNOCK2;
                    note_command(CMD_SET_RATE);
                end
            end
            PH_KNOCK2: begin
                if (rx == RX_ACK) begin
                    host_phase = PH_KNOCK3;
                    note_command(RATE_100);
                end
            end
            PH_KNOCK3: begin
                if (rx == RX_ACK) begin
                    host_phase = PH_KNOCK4;
                    note_command(CMD_SET_RATE);
                end
            end
            PH_KNOCK4: begin
                if (rx == RX_ACK) begin
                    host_phase = PH_KNOCK5;
                    note_command(RATE_80);
                end
            end
            PH_KNOCK5: begin
                if (rx == RX_ACK) begin
                    host_phase = PH_WAIT_ID;
                    note_command(CMD_GET_ID);
                end
            end
            PH_WAIT_ID: begin
                if (rx == ID_STANDARD) begin
                    wheel_mode = 1'b0;
                    host_phase = PH_STD_ACK;
                    note_command(CMD_ENABLE);
                end else if (rx == ID_WHEEL) begin
                    wheel_mode = 1'b1;
                    host_phase = PH_WHL_ACK;
                    note_command(CMD_ENABLE);
                end else if (rx != RX_ACK) begin
                    // unknown id: start over, mouse type untouched
                    host_phase = PH_WAIT_ACK;
                    note_command(CMD_RESET);
                end
            end
            PH_STD_ACK: begin
                if (rx == RX_ACK) host_phase = PH_STD_HDR;
            end
            PH_STD_HDR: begin
                if ((rx & HDR_MASK) == HDR_MATCH) begin
                    pkt_hdr    = rx;
                    host_phase = PH_STD_X;
                end
            end
            PH_STD_X: begin
                pkt_x      = rx;
                host_phase = PH_STD_Y;
            end
            PH_STD_Y: begin
                pkt_y      = rx;
                host_phase = PH_STD_HDR;
                note_report(4'd0, 1'b0);
            end
            PH_WHL_ACK: begin
                if (rx == RX_ACK) host_phase = PH_WHL_HDR;
            end
            PH_WHL_HDR: begin
                if ((rx & HDR_MASK) == HDR_MATCH) begin
                    pkt_hdr    = rx;
                    host_phase = PH_WHL_X;
                end
            end
            PH_WHL_X: begin
                pkt_x      = rx;
                host_phase = PH_WHL_Y;
            end
            PH_WHL_Y: begin
                pkt_y      = rx;
                host_phase = PH_WHL_Z;
            end
            PH_WHL_Z: begin
                host_phase = PH_WHL_HDR;
                note_report(rx[3:0], 1'b1);
            end
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    // a stray byte that cannot move the start-up sequence on by accident
    function automatic logic [7:0] noise_byte();
        logic [7:0] b;
        do begin
            b = 8'($urandom_range(0, 255));
        end while (b == RX_ACK || b == RX_BAT_PASS || b == ID_STANDARD || b == ID_WHEEL);
        return b;
    endfunction

    // one start-up attempt closed by the given id byte
    function automatic void queue_bring_up(input logic [7:0] id);
        logic [7:0] seq[$];
        seq = {RX_ACK, RX_BAT_PASS, RX_ACK, RX_ACK, RX_ACK, RX_ACK, RX_ACK, RX_ACK};
        foreach (seq[i]) begin
            if ($urandom_range(0, 5) == 0) rx_backlog.push_back(noise_byte());
            rx_backlog.push_back(seq[i]);
        end
        // an acknowledge while waiting for the id is ignored
        if ($urandom_range(0, 3) == 0) rx_backlog.push_back(RX_ACK);
        rx_backlog.push_back(id);
    endfunction

    // packet of len bytes; a len below the mode's size gives a broken packet
    function automatic void queue_packet(input logic [7:0] hdr, input logic [7:0] dx,
                                         input logic [7:0] dy, input logic [7:0] dz,
                                         input int len);
        rx_backlog.push_back(hdr);
        if (len > 1) rx_backlog.push_back(dx);
        if (len > 2) rx_backlog.push_back(dy);
        if (len > 3) rx_backlog.push_back(dz);
    endfunction

    function automatic pace_t current_pace();
        return pace_t'((bytes_accepted / PaceSpan) % 4);
    endfunction

    // idle percentage for one side in the current phase
    function automatic int idle_pct(input pace_t own);
        pace_t p;
        p = current_pace();
        if (p == own) return 49;
        if (p == PACE_BOTH) return 20;
        return 0;
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            error_count++;
        end
    endfunction

    // ------------------------------------------------------------------------
    // stimulus, reset and end of run
    // ------------------------------------------------------------------------
    initial begin : stimulus
        logic [7:0] hdr;
        logic [7:0] stray;
        int         pkt_len;
        int         pick;

        // directed start-up: stray bytes in the handshake, an acknowledge
        // while waiting for the id, then two unknown ids (all ones, top bit)
        rx_backlog = {8'h55, RX_ACK, 8'h13, RX_BAT_PASS,
                      RX_ACK, 8'h7E, RX_ACK, RX_ACK, RX_ACK, RX_ACK, RX_ACK,
                      RX_ACK, 8'hFF,
                      RX_ACK, RX_BAT_PASS, RX_ACK, RX_ACK, RX_ACK, RX_ACK,
                      RX_ACK, RX_ACK, 8'h80};

        // a few more failed attempts with random ids
        repeat ($urandom_range(2, 5)) queue_bring_up(noise_byte());

        // the mouse type is fixed for good once reporting starts, so the seed
        // decides which packet path this run exercises
        pkt_len = ($urandom_range(0, 1) == 1) ? 4 : 3;
        queue_bring_up((pkt_len == 4) ? ID_WHEEL : ID_STANDARD);
        if ($urandom_range(0, 1) == 1) rx_backlog.push_back(noise_byte());
        rx_backlog.push_back(RX_ACK);

        // movement extremes: x -256 / y +256 / wheel -8, then x 255 / y -255 /
        // wheel 7, then mid-scale values with every low header bit set
        queue_packet(8'h38, 8'h00, 8'h00, 8'h08, pkt_len);
        queue_packet(8'h08, 8'hFF, 8'hFF, 8'h07, pkt_len);
        queue_packet(8'h0F, 8'h80, 8'h7F, 8'hF0, pkt_len);

        // mostly well-formed packets, the rest filler and broken packets
        while (rx_backlog.size() < StimBytes) begin
            pick = $urandom_range(0, 99);
            hdr  = (8'($urandom_range(0, 255)) & 8'h37) | HDR_MATCH;
            if (pick < 80) begin
                queue_packet(hdr, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                             8'($urandom_range(0, 255)), pkt_len);
            end else if (pick < 90) begin
                // out of sync filler that never passes as a header
                do begin
                    stray = 8'($urandom_range(0, 255));
                end while ((stray & HDR_MASK) == HDR_MATCH);
                rx_backlog.push_back(stray);
            end else if (pick < 95) begin
                queue_packet(hdr, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                             8'($urandom_range(0, 255)), $urandom_range(1, pkt_len - 1));
            end else begin
                rx_backlog.push_back(8'($urandom_range(0, 255)));
            end
        end

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        while (rx_backlog.size() != 0 || s_tvalid) @(posedge aclk);
        while (awaited_results.size() != 0) @(posedge aclk);
        // two-stage pipe: a closing idle tail catches any stray result
        repeat (TailCycles) @(posedge aclk);
        if (error_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // ------------------------------------------------------------------------
    // byte driver: holds a byte until its transaction completes
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin : rx_driver
        logic offer;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            offer = s_tvalid;
            if (s_tvalid && s_tready) begin
                decode_mouse_byte(s_tdata);
                bytes_accepted <= bytes_accepted + 1;
                offer = 1'b0;
            end
            if (!offer && rx_backlog.size() != 0 &&
                $urandom_range(0, 99) >= idle_pct(PACE_SENDER)) begin
                s_tdata <= rx_backlog.pop_front();
                offer = 1'b1;
            end
            s_tvalid <= offer;
        end
    end

    // ------------------------------------------------------------------------
    // long receiver hold-off: one stretch of cycles while the sender keeps
    // offering, so the pipe fills and the input side has to stall
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin : hold_counter
        if (!aresetn) begin
            hold_left <= 0;
        end else if (!hold_done && bytes_accepted >= HoldStart) begin
            hold_left <= HoldCycles;
            hold_done <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // ------------------------------------------------------------------------
    // result monitor and receiver back-pressure
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin : result_monitor
        mouse_result_t got;
        mouse_result_t want;
        logic          ready_next;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.kind   = m_tuser;
                got.cmd    = m_tdata[CMD_LSB +: 8];
                got.status = m_tdata[STATUS_LSB +: 8];
                got.dx     = m_tdata[X_LSB +: 9];
                got.dy     = m_tdata[Y_LSB +: 10];
                got.wheel  = m_tdata[WHEEL_LSB +: 4];
                got.wflag  = m_tdata[HASW_BIT];
                if (awaited_results.size() == 0) begin
                    $error("result with nothing awaited: kind %0d, tdata %h",
                           got.kind, m_tdata);
                    error_count++;
                end else begin
                    want = awaited_results.pop_front();
                    check_field("result_kind", want.kind, got.kind);
                    check_field("command_byte", want.cmd, got.cmd);
                    check_field("status_byte", want.status, got.status);
                    check_field("move_x", $signed(want.dx), $signed(got.dx));
                    check_field("move_y", $signed(want.dy), $signed(got.dy));
                    check_field("wheel", $signed(want.wheel), $signed(got.wheel));
                    check_field("has_wheel", want.wflag, got.wflag);
                end
            end

            if (hold_left > 0) begin
                ready_next = 1'b0;
            end else begin
                ready_next = ($urandom_range(0, 99) >= idle_pct(PACE_RECEIVER));
            end
            m_tready <= ready_next;
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit) begin
            $display("== FAIL ==");
            $finish;
        end
    end

endmodule

@@ files.f @@
design/ps2m_pkg.sv
design/ps2_mouse_init_and_packet_decoder.sv
design/ps2m_checker.sv
sim/testbench.sv
